// ----- sv/bblt_pkg.sv -----
// Shared constants and types for the beam-break lap timer.
// Depends on nothing; used by sv/beam_break_lap_timer.sv.
`default_nettype none

package bblt_pkg;

   // Width of the internal time base; stamps and intervals wrap at this width.
   localparam int TIME_WIDTH = 32;

   // Width of the shared serial divider; must cover the time base and 32-bit rates.
   localparam int DIV_W = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;
   localparam int DIV_CNT_W = $clog2(DIV_W + 1);

   // Rate numerator: 1e6 us/s scaled by 256 for 24.8 fixed point.
   localparam int RATE_NUM_BITS = 28;
   localparam logic [RATE_NUM_BITS-1:0] RATE_NUM = RATE_NUM_BITS'(256000000);

   // Operand widths that drive the serial step counts.
   localparam int LAP_NUM_BITS  = 16;
   localparam int MEAN_NUM_BITS = 32;

   // Left-align shifts so each division runs only as many steps as its dividend has bits.
   localparam int GATE_SHIFT = DIV_W - TIME_WIDTH;
   localparam int LAP_SHIFT  = DIV_W - LAP_NUM_BITS;
   localparam int RATE_SHIFT = DIV_W - RATE_NUM_BITS;
   localparam int MEAN_SHIFT = DIV_W - MEAN_NUM_BITS;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_DETECTION_MODE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ADC_THRESHOLD  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CROSS_PER_LAP  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_IR_PERIOD      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_IR_HIGH        = 3'd4;

   // Detection modes.
   localparam logic [1:0] MODE_ADC   = 2'd0;
   localparam logic [1:0] MODE_PHOTO = 2'd1;
   localparam logic [1:0] MODE_IR    = 2'd2;

   // Reset values of the configuration registers.
   localparam logic [11:0] ADC_THRESHOLD_RST = 12'd2048;
   localparam logic [7:0]  CROSS_PER_LAP_RST = 8'd1;
   localparam logic [15:0] IR_PERIOD_RST     = 16'd1000;
   localparam logic [15:0] IR_HIGH_RST       = 16'd500;

   typedef enum logic [1:0] {
      PHASE_NONE = 2'd0,
      PHASE_RECV = 2'd1,
      PHASE_INTR = 2'd2
   } phase_type;

endpackage

`default_nettype wire

// ----- sv/beam_break_lap_timer.sv -----
// Beam-break lap timer: sensor flag, beam phase tracking, lap stamps, mean poll rate.
// Depends on bblt_pkg (constants, phase type); one shared serial divider does all divisions.
`default_nettype none

//  channel | ports                          | direction | moves
//  --------+--------------------------------+-----------+--------------------------------
//  req     | req_valid/req_stall + fields   | in        | one poll tick per beat
//  rsp     | rsp_valid/rsp_stall + fields   | out       | one result per tick beat
//  csr     | csr_write/csr_index/csr_wdata  | in        | one register write, no wait
//
//  An update tick runs the shared restoring divider, one quotient bit per cycle,
//  for the lap multiple, the instant rate and the mean step; in IR mode every tick
//  first runs it for the window test. A tick that makes no update skips the rest.
//  Synchronous reset clears phase, counters, stamps and mean rate, and loads the
//  register defaults.
//  req_stall stays high from accept until the result beat leaves; rsp holds while stalled.

module beam_break_lap_timer (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // poll tick input
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [31:0]                   req_time_us,
   input  wire logic [11:0]                   req_adc_sample,
   input  wire logic                          req_photo_level,
   input  wire logic                          req_ir_level,
   // result output
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_updated,
   output logic                               rsp_beam_received,
   output logic [1:0]                         rsp_beam_phase,
   output logic [15:0]                        rsp_crossing_count,
   output logic [31:0]                        rsp_start_time_out,
   output logic [31:0]                        rsp_finish_time_out,
   output logic [31:0]                        rsp_mean_rate_hz,
   output logic [31:0]                        rsp_sample_total,
   // configuration writes
   input  wire logic                          csr_write,
   input  wire logic [bblt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [bblt_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int TW = bblt_pkg::TIME_WIDTH;
   localparam int DW = bblt_pkg::DIV_W;
   localparam int CW = bblt_pkg::DIV_CNT_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_GATE,
      S_APPLY,
      S_LAP,
      S_RATE,
      S_MEAN,
      S_DONE
   } state_type;

   // sequencer and architectural state
   state_type            state_ff,   state_in;
   bblt_pkg::phase_type  phase_ff,   phase_in;
   logic [15:0]          cross_ff,   cross_in;
   logic [TW-1:0]        start_ff,   start_in;
   logic [TW-1:0]        finish_ff,  finish_in;
   logic [TW-1:0]        last_ff,    last_in;
   logic [31:0]          sample_ff,  sample_in;
   logic [31:0]          mean_ff,    mean_in;
   logic                 upd_ff,     upd_in;
   logic                 recv_ff,    recv_in;

   // configuration registers
   logic [1:0]           mode_ff,    mode_in;
   logic [11:0]          thresh_ff,  thresh_in;
   logic [7:0]           lap_ff,     lap_in;
   logic [15:0]          period_ff,  period_in;
   logic [15:0]          high_ff,    high_in;

   // tick payload and working values
   logic [TW-1:0]        t_ff,       t_in;
   logic                 ir_ff,      ir_in;
   logic                 rx_ff,      rx_in;
   logic                 dir_ff,     dir_in;

   // shared divider
   logic [CW-1:0]        div_cnt_ff, div_cnt_in;
   logic [DW-1:0]        div_quo_ff, div_quo_in;
   logic [DW-1:0]        div_rem_ff, div_rem_in;
   logic [DW-1:0]        div_den_ff, div_den_in;

   logic                 div_start;
   logic [DW-1:0]        div_num;
   logic [DW-1:0]        div_den;
   logic [CW-1:0]        div_steps;
   logic                 div_done;

   logic [DW:0]          div_shift;
   logic                 div_ge;
   logic [DW:0]          div_diff;

   logic [TW-1:0]        interval;
   logic [31:0]          inst_rate;
   logic [31:0]          mean_step;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);

   assign rsp_updated         = upd_ff;
   assign rsp_beam_received   = recv_ff;
   assign rsp_beam_phase      = phase_ff;
   assign rsp_crossing_count  = cross_ff;
   assign rsp_start_time_out  = 32'(start_ff);
   assign rsp_finish_time_out = 32'(finish_ff);
   assign rsp_mean_rate_hz    = mean_ff;
   assign rsp_sample_total    = sample_ff;

   // One restoring step: shift in the next dividend bit, subtract when it fits.
   assign div_shift = {div_rem_ff, div_quo_ff[DW-1]};
   assign div_ge    = (div_shift >= {1'b0, div_den_ff});
   assign div_diff  = div_shift - {1'b0, div_den_ff};
   assign div_done  = (div_cnt_ff == '0);

   // Interval since the last update wraps with the time base.
   assign interval  = t_ff - last_ff;
   assign inst_rate = (interval == '0) ? 32'hFFFF_FFFF : div_quo_ff[31:0];
   // Round the downward step up so the mean floors toward the instant rate.
   assign mean_step = div_quo_ff[31:0] + 32'(div_rem_ff != '0);

   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      cross_in   = cross_ff;
      start_in   = start_ff;
      finish_in  = finish_ff;
      last_in    = last_ff;
      sample_in  = sample_ff;
      mean_in    = mean_ff;
      upd_in     = upd_ff;
      recv_in    = recv_ff;
      mode_in    = mode_ff;
      thresh_in  = thresh_ff;
      lap_in     = lap_ff;
      period_in  = period_ff;
      high_in    = high_ff;
      t_in       = t_ff;
      ir_in      = ir_ff;
      rx_in      = rx_ff;
      dir_in     = dir_ff;
      div_start  = 1'b0;
      div_num    = '0;
      div_den    = '0;
      div_steps  = '0;

      // register writes are to arrive only while the block is idle; the block itself does not enforce it
      if (csr_write) begin
         unique case (csr_index)
            bblt_pkg::CSR_DETECTION_MODE: mode_in   = csr_wdata[1:0];
            bblt_pkg::CSR_ADC_THRESHOLD:  thresh_in = csr_wdata[11:0];
            bblt_pkg::CSR_CROSS_PER_LAP:  lap_in    = csr_wdata[7:0];
            bblt_pkg::CSR_IR_PERIOD:      period_in = csr_wdata[15:0];
            bblt_pkg::CSR_IR_HIGH:        high_in   = csr_wdata[15:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               t_in    = TW'(req_time_us);
               ir_in   = req_ir_level;
               upd_in  = 1'b0;
               recv_in = 1'b0;
               unique case (mode_ff)
                  bblt_pkg::MODE_ADC: begin
                     rx_in = (req_adc_sample > thresh_ff);
                     if (phase_ff == bblt_pkg::PHASE_NONE && !rx_in) begin
                        state_in = S_DONE;
                     end else begin
                        state_in = S_APPLY;
                     end
                  end
                  bblt_pkg::MODE_PHOTO: begin
                     rx_in = req_photo_level;
                     if (phase_ff == bblt_pkg::PHASE_NONE && !rx_in) begin
                        state_in = S_DONE;
                     end else begin
                        state_in = S_APPLY;
                     end
                  end
                  bblt_pkg::MODE_IR: begin
                     // time mod period gates the IR receiver; zero period acts as one
                     div_start = 1'b1;
                     div_num   = DW'(TW'(req_time_us)) << bblt_pkg::GATE_SHIFT;
                     div_den   = (period_ff == '0) ? DW'(1) : DW'(period_ff);
                     div_steps = CW'(TW);
                     state_in  = S_GATE;
                  end
                  default: begin
                     // no sensor selected: report without update
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         S_GATE: begin
            if (div_done) begin
               rx_in = !ir_ff;
               if (div_rem_ff > DW'(high_ff)) begin
                  state_in = S_DONE;
               end else if (phase_ff == bblt_pkg::PHASE_NONE && ir_ff) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_APPLY;
               end
            end
         end

         S_APPLY: begin
            priority if (phase_ff == bblt_pkg::PHASE_RECV && !rx_ff && cross_ff == '0) begin
               start_in = t_ff;
            end else if (phase_ff == bblt_pkg::PHASE_INTR && rx_ff && cross_ff != 16'hFFFF) begin
               cross_in = cross_ff + 16'd1;
            end
            phase_in = rx_ff ? bblt_pkg::PHASE_RECV : bblt_pkg::PHASE_INTR;
            if (sample_ff != 32'hFFFF_FFFF) begin
               sample_in = sample_ff + 32'd1;
            end
            // test the new count against the lap multiple; zero acts as one
            div_start = 1'b1;
            div_num   = DW'(cross_in) << bblt_pkg::LAP_SHIFT;
            div_den   = (lap_ff == '0) ? DW'(1) : DW'(lap_ff);
            div_steps = CW'(bblt_pkg::LAP_NUM_BITS);
            state_in  = S_LAP;
         end

         S_LAP: begin
            if (div_done) begin
               if (cross_ff != '0 && div_rem_ff == '0) begin
                  finish_in = t_ff;
               end
               div_start = 1'b1;
               div_num   = DW'(bblt_pkg::RATE_NUM) << bblt_pkg::RATE_SHIFT;
               div_den   = DW'(interval);
               div_steps = CW'(bblt_pkg::RATE_NUM_BITS);
               state_in  = S_RATE;
            end
         end

         S_RATE: begin
            if (div_done) begin
               dir_in    = (inst_rate >= mean_ff);
               div_start = 1'b1;
               div_num   = (dir_in ? DW'(inst_rate - mean_ff) : DW'(mean_ff - inst_rate))
                           << bblt_pkg::MEAN_SHIFT;
               div_den   = DW'(sample_ff);
               div_steps = CW'(bblt_pkg::MEAN_NUM_BITS);
               state_in  = S_MEAN;
            end
         end

         S_MEAN: begin
            if (div_done) begin
               mean_in  = dir_ff ? (mean_ff + div_quo_ff[31:0]) : (mean_ff - mean_step);
               last_in  = t_ff;
               upd_in   = 1'b1;
               recv_in  = rx_ff;
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase

      // shared divider: load on start, else one quotient bit per cycle until the count runs out
      div_cnt_in = div_cnt_ff;
      div_quo_in = div_quo_ff;
      div_rem_in = div_rem_ff;
      div_den_in = div_den_ff;
      if (div_start) begin
         div_cnt_in = div_steps;
         div_quo_in = div_num;
         div_rem_in = '0;
         div_den_in = div_den;
      end else if (!div_done) begin
         div_cnt_in = div_cnt_ff - CW'(1);
         div_quo_in = {div_quo_ff[DW-2:0], div_ge};
         div_rem_in = div_ge ? div_diff[DW-1:0] : div_shift[DW-1:0];
      end
   end

   // control, architectural state and registered result flags
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         phase_ff   <= bblt_pkg::PHASE_NONE;
         cross_ff   <= '0;
         start_ff   <= '0;
         finish_ff  <= '0;
         last_ff    <= '0;
         sample_ff  <= '0;
         mean_ff    <= '0;
         upd_ff     <= 1'b0;
         recv_ff    <= 1'b0;
         mode_ff    <= bblt_pkg::MODE_ADC;
         thresh_ff  <= bblt_pkg::ADC_THRESHOLD_RST;
         lap_ff     <= bblt_pkg::CROSS_PER_LAP_RST;
         period_ff  <= bblt_pkg::IR_PERIOD_RST;
         high_ff    <= bblt_pkg::IR_HIGH_RST;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         phase_ff   <= phase_in;
         cross_ff   <= cross_in;
         start_ff   <= start_in;
         finish_ff  <= finish_in;
         last_ff    <= last_in;
         sample_ff  <= sample_in;
         mean_ff    <= mean_in;
         upd_ff     <= upd_in;
         recv_ff    <= recv_in;
         mode_ff    <= mode_in;
         thresh_ff  <= thresh_in;
         lap_ff     <= lap_in;
         period_ff  <= period_in;
         high_ff    <= high_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   // payload and divider datapath, no reset
   always_ff @(posedge clock) begin
      t_ff       <= t_in;
      ir_ff      <= ir_in;
      rx_ff      <= rx_in;
      dir_ff     <= dir_in;
      div_quo_ff <= div_quo_in;
      div_rem_ff <= div_rem_in;
      div_den_ff <= div_den_in;
   end

endmodule

`default_nettype wire
